/* hdl/rgbhsv_pkg.sv */
`default_nettype none
package rgbhsv_pkg;

	localparam int CHAN_W      = 8;
	localparam int SAT_W       = 8;
	localparam int HUE_INT_W   = 9;
	localparam int DIV_W       = 9;
	localparam int NUM_BASE_W  = 18;
	localparam int T_W         = 11;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

endpackage
`default_nettype wire

/* hdl/rgbhsv_if.sv */
`default_nettype none
interface rgbhsv_rgb_if;
	import rgbhsv_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsv_hsv_if #(
	parameter int HUE_W = 15
);
	import rgbhsv_pkg::*;

	logic              valid;
	logic              ready;
	logic [HUE_W-1:0]  hue;
	logic [SAT_W-1:0]  saturation;
	logic [CHAN_W-1:0] brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink   (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface
`default_nettype wire

/* hdl/rgbhsv_front.sv */
`default_nettype none
module rgbhsv_front #(
	parameter int HUE_FRAC_BITS = 6
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	rgbhsv_rgb_if.sink                                       rgb,
	output      logic                                        out_valid,
	input  wire logic                                        out_ready,
	output      logic [rgbhsv_pkg::NUM_BASE_W+HUE_FRAC_BITS-1:0] hue_num,
	output      logic [rgbhsv_pkg::DIV_W-1:0]                hue_div,
	output      logic [rgbhsv_pkg::NUM_BASE_W+HUE_FRAC_BITS-1:0] sat_num,
	output      logic [rgbhsv_pkg::DIV_W-1:0]                sat_div,
	output      logic                                        gray,
	output      logic                                        black,
	output      logic [rgbhsv_pkg::CHAN_W-1:0]               bright
);
	import rgbhsv_pkg::*;

	localparam int NW        = NUM_BASE_W + HUE_FRAC_BITS;
	localparam int HUE_SCALE = 120 << HUE_FRAC_BITS;

	logic              en;
	logic              v_s1, v_s2;
	logic [CHAN_W-1:0] hi_c, lo_c, delta_c;
	sector_t           sect_c;
	logic [T_W-1:0]    t_c, d_c;
	logic [CHAN_W-1:0] hi_s1, delta_s1;
	logic [T_W-1:0]    t_s1;

	assign en        = !v_s2 || out_ready;
	assign rgb.ready = en;
	assign out_valid = v_s2;

	always_comb begin
		hi_c = rgb.red;
		if (rgb.green > hi_c) hi_c = rgb.green;
		if (rgb.blue > hi_c) hi_c = rgb.blue;
		lo_c = rgb.red;
		if (rgb.green < lo_c) lo_c = rgb.green;
		if (rgb.blue < lo_c) lo_c = rgb.blue;
		delta_c = hi_c - lo_c;
		if (rgb.red == hi_c) sect_c = SECT_RED;
		else if (rgb.green == hi_c) sect_c = SECT_GREEN;
		else sect_c = SECT_BLUE;
	end

	// offset*delta + difference, kept modulo 2^T_W; the true value is below 6*delta
	always_comb begin
		d_c = T_W'(delta_c);
		unique case (sect_c)
			SECT_RED: begin
				t_c = T_W'(rgb.green) - T_W'(rgb.blue);
				if (rgb.green < rgb.blue) t_c = t_c + (d_c << 2) + (d_c << 1);
			end
			SECT_GREEN: t_c = (d_c << 1) + T_W'(rgb.blue) - T_W'(rgb.red);
			SECT_BLUE:  t_c = (d_c << 2) + T_W'(rgb.red) - T_W'(rgb.green);
			default:    t_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= rgb.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s1    <= hi_c;
			delta_s1 <= delta_c;
			t_s1     <= t_c;
			hue_num  <= NW'(t_s1) * NW'(HUE_SCALE) + NW'(delta_s1);
			hue_div  <= {delta_s1, 1'b0};
			sat_num  <= NW'(delta_s1) * NW'(510) + NW'(hi_s1);
			sat_div  <= {hi_s1, 1'b0};
			gray     <= (delta_s1 == '0);
			black    <= (hi_s1 == '0);
			bright   <= hi_s1;
		end
	end

endmodule
`default_nettype wire

/* hdl/rgbhsv_queue.sv */
`default_nettype none
module rgbhsv_queue #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output      logic             full,
	input  wire logic             pop,
	output      logic [WIDTH-1:0] rdata,
	output      logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

/* hdl/rgbhsv_back.sv */
`default_nettype none
module rgbhsv_back #(
	parameter int HUE_FRAC_BITS = 6
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        in_valid,
	output      logic                                        in_ready,
	input  wire logic [rgbhsv_pkg::NUM_BASE_W+HUE_FRAC_BITS-1:0] hue_num,
	input  wire logic [rgbhsv_pkg::DIV_W-1:0]                hue_div,
	input  wire logic [rgbhsv_pkg::NUM_BASE_W+HUE_FRAC_BITS-1:0] sat_num,
	input  wire logic [rgbhsv_pkg::DIV_W-1:0]                sat_div,
	input  wire logic                                        gray,
	input  wire logic                                        black,
	input  wire logic [rgbhsv_pkg::CHAN_W-1:0]               bright,
	rgbhsv_hsv_if.source                                     hsv
);
	import rgbhsv_pkg::*;

	localparam int HW   = HUE_INT_W + HUE_FRAC_BITS;
	localparam int NW   = NUM_BASE_W + HUE_FRAC_BITS;
	localparam int FULL = 360 << HUE_FRAC_BITS;

	function automatic logic [DIV_W+HW-1:0] div_step(
		input logic [DIV_W-1:0] rem,
		input logic [HW-1:0]    low,
		input logic [DIV_W-1:0] dvs
	);
		logic [DIV_W:0] trial;
		logic [DIV_W:0] diff;
		trial = {rem, low[HW-1]};
		diff  = trial - {1'b0, dvs};
		if (trial >= {1'b0, dvs}) return {diff[DIV_W-1:0], low[HW-2:0], 1'b1};
		else return {trial[DIV_W-1:0], low[HW-2:0], 1'b0};
	endfunction

	logic              en;
	logic              vld_s   [HW+1];
	logic [DIV_W-1:0]  hrem_s  [HW+1];
	logic [HW-1:0]     hlow_s  [HW+1];
	logic [DIV_W-1:0]  hdiv_s  [HW+1];
	logic [DIV_W-1:0]  srem_s  [HW+1];
	logic [HW-1:0]     slow_s  [HW+1];
	logic [DIV_W-1:0]  sdiv_s  [HW+1];
	logic              gray_s  [HW+1];
	logic              black_s [HW+1];
	logic [CHAN_W-1:0] bri_s   [HW+1];
	logic              out_valid_q;
	logic [HW-1:0]     hue_q;
	logic [SAT_W-1:0]  sat_q;
	logic [CHAN_W-1:0] bri_q;

	assign en             = !out_valid_q || hsv.ready;
	assign in_ready       = en;
	assign hsv.valid      = out_valid_q;
	assign hsv.hue        = hue_q;
	assign hsv.saturation = sat_q;
	assign hsv.brightness = bri_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hrem_s[0]  <= hue_num[NW-1:HW];
			hlow_s[0]  <= hue_num[HW-1:0];
			hdiv_s[0]  <= hue_div;
			srem_s[0]  <= sat_num[NW-1:HW];
			slow_s[0]  <= sat_num[HW-1:0];
			sdiv_s[0]  <= sat_div;
			gray_s[0]  <= gray;
			black_s[0] <= black;
			bri_s[0]   <= bright;
		end
	end

	for (genvar k = 0; k < HW; k++) begin : g_step
		logic [DIV_W+HW-1:0] hnext, snext;

		always_comb begin
			hnext = div_step(hrem_s[k], hlow_s[k], hdiv_s[k]);
			snext = div_step(srem_s[k], slow_s[k], sdiv_s[k]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				{hrem_s[k+1], hlow_s[k+1]} <= hnext;
				{srem_s[k+1], slow_s[k+1]} <= snext;
				hdiv_s[k+1]  <= hdiv_s[k];
				sdiv_s[k+1]  <= sdiv_s[k];
				gray_s[k+1]  <= gray_s[k];
				black_s[k+1] <= black_s[k];
				bri_s[k+1]   <= bri_s[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_s[HW];
		end
	end

	// drop hue for gray pixels and wrap a full turn to zero
	always_ff @(posedge clk) begin
		if (en) begin
			hue_q <= (gray_s[HW] || hlow_s[HW] >= HW'(FULL)) ? '0 : hlow_s[HW];
			sat_q <= black_s[HW] ? '0 : slow_s[HW][SAT_W-1:0];
			bri_q <= bri_s[HW];
		end
	end

endmodule
`default_nettype wire

/* hdl/rgb_to_hsv_pixel_converter_top.sv */
// Channel   Direction  Payload                                       Handshake
// rgb       in         red[7:0], green[7:0], blue[7:0]               valid/ready
// hsv       out        hue[8+HUE_FRAC_BITS:0], saturation[7:0],      valid/ready
//                      brightness[7:0]
//
// One item per clock sustained while the hsv output is ready; items are independent.
// Each accepted item passes, after the front's first stage, through its second stage, one
// queue slot, a divider input register, 9 + HUE_FRAC_BITS restoring divider stages that each
// form one quotient bit of hue and of saturation, then an output register.
// A stalled output holds the divider; the four-entry queue lets the front keep taking items.
// Reset clears only valid flags, queue pointers and the queue count.
`default_nettype none
module rgb_to_hsv_pixel_converter_top #(
	parameter int HUE_FRAC_BITS = 6
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rgbhsv_rgb_if.sink   rgb,
	rgbhsv_hsv_if.source hsv
);
	import rgbhsv_pkg::*;

	localparam int NW = NUM_BASE_W + HUE_FRAC_BITS;
	localparam int QW = 2 * NW + 2 * DIV_W + 2 + CHAN_W;

	logic              f_valid, q_full, q_empty, b_ready;
	logic [NW-1:0]     f_hue_num, f_sat_num, b_hue_num, b_sat_num;
	logic [DIV_W-1:0]  f_hue_div, f_sat_div, b_hue_div, b_sat_div;
	logic              f_gray, f_black, b_gray, b_black;
	logic [CHAN_W-1:0] f_bright, b_bright;
	logic [QW-1:0]     q_wdata, q_rdata;

	rgbhsv_front #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rgb      (rgb),
		.out_valid(f_valid),
		.out_ready(!q_full),
		.hue_num  (f_hue_num),
		.hue_div  (f_hue_div),
		.sat_num  (f_sat_num),
		.sat_div  (f_sat_div),
		.gray     (f_gray),
		.black    (f_black),
		.bright   (f_bright)
	);

	assign q_wdata = {f_hue_num, f_hue_div, f_sat_num, f_sat_div, f_gray, f_black, f_bright};

	rgbhsv_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_valid),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (b_ready),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	assign {b_hue_num, b_hue_div, b_sat_num, b_sat_div, b_gray, b_black, b_bright} = q_rdata;

	rgbhsv_back #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(!q_empty),
		.in_ready(b_ready),
		.hue_num (b_hue_num),
		.hue_div (b_hue_div),
		.sat_num (b_sat_num),
		.sat_div (b_sat_div),
		.gray    (b_gray),
		.black   (b_black),
		.bright  (b_bright),
		.hsv     (hsv)
	);

endmodule
`default_nettype wire

/* tb/hsv_result_checker.sv */
module hsv_result_checker #(
	parameter int HUE_FRAC_BITS = 6
) (
	input  logic         clk,
	input  logic         arst_n,
	rgbhsv_rgb_if        rgb,
	rgbhsv_hsv_if        hsv,
	output int unsigned  mismatch_count,
	output int unsigned  hsv_pending
);
	import rgbhsv_pkg::*;

	localparam int HUE_W = HUE_INT_W + HUE_FRAC_BITS;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [SAT_W-1:0]  saturation;
		logic [CHAN_W-1:0] brightness;
	} hsv_pixel_t;

	hsv_pixel_t  hsv_expected_q[$];
	int unsigned errors  = 0;
	int unsigned waiting = 0;

	assign mismatch_count = errors;
	assign hsv_pending    = waiting;

	function automatic hsv_pixel_t predict_hsv(input logic [CHAN_W-1:0] r, g, b);
		sector_t    sector;
		int         hi;
		int         lo;
		int         delta;
		int         t;
		int         hue_val;
		hsv_pixel_t px;
		hi     = int'(r);
		sector = SECT_RED;
		if (int'(g) > hi) begin
			hi     = int'(g);
			sector = SECT_GREEN;
		end
		if (int'(b) > hi) begin
			hi     = int'(b);
			sector = SECT_BLUE;
		end
		lo = int'(r);
		if (int'(g) < lo)
			lo = int'(g);
		if (int'(b) < lo)
			lo = int'(b);
		delta = hi - lo;
		px    = '0;
		px.brightness = hi[CHAN_W-1:0];
		if (hi != 0) begin
			t = (delta * 510 + hi) / (2 * hi);
			px.saturation = t[SAT_W-1:0];
		end
		if (delta != 0) begin
			case (sector)
				SECT_RED:   t = int'(g) - int'(b);
				SECT_GREEN: t = 2 * delta + int'(b) - int'(r);
				default:    t = 4 * delta + int'(r) - int'(g);
			endcase
			if (t < 0)
				t += 6 * delta;
			hue_val = (t * (120 << HUE_FRAC_BITS) + delta) / (2 * delta);
			if (hue_val >= (360 << HUE_FRAC_BITS))
				hue_val = 0;
			px.hue = hue_val[HUE_W-1:0];
		end
		return px;
	endfunction

	always @(posedge clk) begin
		hsv_pixel_t want;
		hsv_pixel_t got;
		if (arst_n) begin
			if (rgb.valid && rgb.ready)
				hsv_expected_q.push_back(predict_hsv(rgb.red, rgb.green, rgb.blue));
			if (hsv.valid && hsv.ready) begin
				got.hue        = hsv.hue;
				got.saturation = hsv.saturation;
				got.brightness = hsv.brightness;
				if (hsv_expected_q.size() == 0) begin
					errors++;
					$display("%0t unexpected hsv item: expected none,", $time,
						" actual hue=%0d sat=%0d val=%0d",
						got.hue, got.saturation, got.brightness);
				end else begin
					want = hsv_expected_q.pop_front();
					if (got.hue !== want.hue || got.saturation !== want.saturation ||
							got.brightness !== want.brightness) begin
						errors++;
						$display("%0t hsv mismatch: expected hue=%0d sat=%0d val=%0d,",
							$time, want.hue, want.saturation, want.brightness,
							" actual hue=%0d sat=%0d val=%0d",
							got.hue, got.saturation, got.brightness);
					end
				end
			end
			waiting = hsv_expected_q.size();
		end
	end

endmodule

/* tb/tb_rgb_to_hsv_pixel_converter_top.sv */
module tb_rgb_to_hsv_pixel_converter_top;
	import rgbhsv_pkg::*;

	localparam int HUE_FRAC_BITS   = 6;
	localparam int HUE_W           = HUE_INT_W + HUE_FRAC_BITS;
	localparam int LATENCY         = HUE_FRAC_BITS + 13;
	localparam int PIXEL_COUNT     = 750;
	localparam int QUIET_TAIL      = 100;
	localparam int HOLD_OFF_AFTER  = 150;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int WATCHDOG_LIMIT  = 4000;

	logic        clk;
	logic        arst_n;
	int unsigned mismatch_count;
	int unsigned hsv_pending;
	int unsigned pixels_sent   = 0;
	int unsigned idle_cycles   = 0;
	bit          quiet         = 1'b0;
	bit          hold_off_done = 1'b0;

	rgbhsv_rgb_if                  rgb_if ();
	rgbhsv_hsv_if #(.HUE_W(HUE_W)) hsv_if ();

	rgb_to_hsv_pixel_converter_top #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rgb    (rgb_if),
		.hsv    (hsv_if)
	);

	hsv_result_checker #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.rgb            (rgb_if),
		.hsv            (hsv_if),
		.mismatch_count (mismatch_count),
		.hsv_pending    (hsv_pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic send_pixel(input logic [CHAN_W-1:0] r, g, b);
		rgb_if.valid <= 1'b1;
		rgb_if.red   <= r;
		rgb_if.green <= g;
		rgb_if.blue  <= b;
		@(posedge clk);
		while (!rgb_if.ready)
			@(posedge clk);
		pixels_sent++;
	endtask

	initial begin
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
		int                i;
		arst_n       <= 1'b0;
		rgb_if.valid <= 1'b0;
		rgb_if.red   <= '0;
		rgb_if.green <= '0;
		rgb_if.blue  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pixel(8'd0,   8'd0,   8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd1,   8'd1,   8'd1);
		send_pixel(8'd255, 8'd0,   8'd0);
		send_pixel(8'd0,   8'd255, 8'd0);
		send_pixel(8'd0,   8'd0,   8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0,   8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd255);
		send_pixel(8'd255, 8'd0,   8'd1);
		send_pixel(8'd255, 8'd1,   8'd0);
		send_pixel(8'd2,   8'd1,   8'd1);
		send_pixel(8'd1,   8'd0,   8'd0);
		send_pixel(8'd0,   8'd0,   8'd1);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd10,  8'd20,  8'd30);
		send_pixel(8'd30,  8'd20,  8'd10);
		send_pixel(8'd20,  8'd30,  8'd10);
		send_pixel(8'd85,  8'd170, 8'd255);
		send_pixel(8'd3,   8'd2,   8'd0);
		send_pixel(8'd3,   8'd0,   8'd2);

		for (i = 0; i < PIXEL_COUNT; i++) begin
			quiet = (i >= PIXEL_COUNT - QUIET_TAIL);
			if (!quiet && (i / 40) % 3 != 2 && $urandom_range(0, 3) == 0) begin
				rgb_if.valid <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			r = CHAN_W'($urandom);
			g = CHAN_W'($urandom);
			b = CHAN_W'($urandom);
			case ($urandom_range(0, 9))
				0, 1: begin
					case ($urandom_range(0, 3))
						0:       g = r;
						1:       b = r;
						2:       b = g;
						default: begin
							g = r;
							b = r;
						end
					endcase
				end
				2: begin
					r = CHAN_W'($urandom_range(0, 3));
					g = CHAN_W'($urandom_range(0, 3));
					b = CHAN_W'($urandom_range(0, 3));
				end
				3: begin
					r = CHAN_W'($urandom_range(0, 1) ? 255 - $urandom_range(0, 1)
						: $urandom_range(0, 1));
					g = CHAN_W'($urandom_range(0, 1) ? 255 - $urandom_range(0, 1)
						: $urandom_range(0, 1));
					b = CHAN_W'($urandom_range(0, 1) ? 255 - $urandom_range(0, 1)
						: $urandom_range(0, 1));
				end
				default: ;
			endcase
			send_pixel(r, g, b);
		end
		rgb_if.valid <= 1'b0;

		while (hsv_pending != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (mismatch_count == 0 && hsv_pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		hsv_if.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (quiet) begin
				hsv_if.ready <= 1'b1;
				@(posedge clk);
			end else if (!hold_off_done && pixels_sent >= HOLD_OFF_AFTER) begin
				hsv_if.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_done = 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				hsv_if.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				hsv_if.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((rgb_if.valid && rgb_if.ready) || (hsv_if.valid && hsv_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

endmodule
